// ----- src/lzbd_pkg.sv -----
// Package for the bit-packed LZ77 decoder: sizes, token layout, controller types.
`default_nettype none
package lzbd_pkg;

  localparam int WINDOW     = 4096;
  localparam int HIST_AW    = $clog2(WINDOW);
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int OFF_W      = 12;
  localparam int BUF_W      = 33;
  localparam int CNT_W      = 6;
  localparam int LIT_BITS   = 9;
  localparam int MATCH_BITS = 26;

  // token field positions in the right-aligned token word
  localparam int NEXT_LSB = 0;
  localparam int LEN_LSB  = BYTE_W;
  localparam int OFF_LSB  = BYTE_W + LEN_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_TAIL
  } lzbd_state_t;

  typedef struct packed {
    logic load;       // take the input byte and decode a token
    logic issue;      // read one history byte for the copy
    logic emit_copy;  // emit the byte fetched for the copy
    logic emit_next;  // emit the token's trailing byte
  } lzbd_cmd_t;

  typedef struct packed {
    logic tok_hit;    // accepting the current byte completes a token
    logic len_zero;   // completed token has no copy part
    logic copy_done;  // all copy reads issued
  } lzbd_status_t;

endpackage
`default_nettype wire

// ----- src/lzbd_datapath.sv -----
// Datapath: bit buffer, token decode, history memory and output register.
`default_nettype none
module lzbd_datapath
  import lzbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_stream_end,
  input  wire lzbd_cmd_t         cmd,
  output lzbd_status_t           st,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_run_last
);

  logic [BUF_W-1:0]   bit_buf_r;
  logic [CNT_W-1:0]   bit_cnt_r;
  logic [BUF_W-1:0]   buf_cat;
  logic [CNT_W-1:0]   cnt_cat;
  logic [BUF_W-1:0]   flag_sh;
  logic               flag;
  logic               hit_lit;
  logic               hit_match;
  logic [CNT_W-1:0]   take;
  logic [CNT_W-1:0]   cnt_left;
  logic [BUF_W-1:0]   tok_sh;
  logic [BUF_W-1:0]   keep_mask;
  logic [OFF_W-1:0]   tok_off;
  logic [LEN_W-1:0]   tok_len;
  logic [HIST_AW-1:0] off_ext;

  logic [LEN_W-1:0]   rem_r;
  logic [HIST_AW-1:0] src_r;
  logic [BYTE_W-1:0]  next_r;
  logic               bypass_r;

  logic [HIST_AW-1:0] wp_r;
  logic               wrap_r;
  logic [BYTE_W-1:0]  last_byte_r;
  logic [BYTE_W-1:0]  rd_data_r;
  logic               rd_ok_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_run_last_r;

  logic               emit;
  logic [BYTE_W-1:0]  emit_byte;

  logic [BYTE_W-1:0]  hist_mem [WINDOW];

  // token decode on the incoming byte
  always_comb begin
    buf_cat   = {bit_buf_r[BUF_W-BYTE_W-1:0], in_data_byte};
    cnt_cat   = bit_cnt_r + CNT_W'(BYTE_W);
    flag_sh   = buf_cat >> (cnt_cat - CNT_W'(1));
    flag      = flag_sh[0];
    hit_lit   = !flag && (cnt_cat >= CNT_W'(LIT_BITS));
    hit_match = flag && (cnt_cat >= CNT_W'(MATCH_BITS));
    priority if (hit_lit) begin
      take = CNT_W'(LIT_BITS);
    end else if (hit_match) begin
      take = CNT_W'(MATCH_BITS);
    end else begin
      take = '0;
    end
    cnt_left  = cnt_cat - take;
    tok_sh    = buf_cat >> cnt_left;
    keep_mask = (BUF_W'(1) << cnt_left) - BUF_W'(1);
    tok_off   = tok_sh[OFF_LSB +: OFF_W];
    tok_len   = tok_sh[LEN_LSB +: LEN_W];
    off_ext   = HIST_AW'(tok_off);
  end

  assign st.tok_hit   = hit_lit || hit_match;
  assign st.len_zero  = !hit_match || (tok_len == '0);
  assign st.copy_done = (rem_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_buf_r <= '0;
      bit_cnt_r <= '0;
    end else if (cmd.load) begin
      bit_buf_r <= in_stream_end ? '0 : (buf_cat & keep_mask);
      bit_cnt_r <= in_stream_end ? '0 : cnt_left;
    end
  end

  // copy counter and source pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (cmd.load) begin
      rem_r <= hit_match ? tok_len : '0;
    end else if (cmd.issue) begin
      rem_r <= rem_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r    <= wp_r + off_ext;
      next_r   <= tok_sh[NEXT_LSB +: BYTE_W];
      // source one byte behind the write slot: read data would be stale
      bypass_r <= (off_ext == HIST_AW'(WINDOW - 1));
    end else if (cmd.issue) begin
      src_r <= src_r + HIST_AW'(1);
    end
  end

  // history is written in slot order from zero, so a slot is written
  // once the write pointer has passed it or has wrapped
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= hist_mem[src_r];
      rd_ok_r   <= wrap_r || (src_r < wp_r);
    end
  end

  assign emit = cmd.emit_copy || cmd.emit_next;

  always_comb begin
    if (cmd.emit_copy) begin
      if (bypass_r) begin
        emit_byte = last_byte_r;
      end else begin
        emit_byte = rd_ok_r ? rd_data_r : '0;
      end
    end else begin
      emit_byte = next_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hist_mem[wp_r] <= emit_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      wrap_r      <= 1'b0;
      last_byte_r <= '0;
    end else if (emit) begin
      wp_r        <= wp_r + HIST_AW'(1);
      last_byte_r <= emit_byte;
      if (wp_r == HIST_AW'(WINDOW - 1)) begin
        wrap_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r     <= emit_byte;
      out_run_last_r <= cmd.emit_next;
    end
  end

  assign out_byte     = out_byte_r;
  assign out_run_last = out_run_last_r;

endmodule
`default_nettype wire

// ----- src/lzbd_ctrl.sv -----
// Controller: sequences token load, history copy reads and byte transfers.
`default_nettype none
module lzbd_ctrl
  import lzbd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         out_stall,
  input  wire lzbd_status_t st,
  output lzbd_cmd_t         cmd,
  output logic              in_stall,
  output logic              out_valid
);

  lzbd_state_t state_r, state_nxt;
  logic        pend_r, pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && st.tok_hit) begin
          state_nxt = st.len_zero ? ST_TAIL : ST_COPY;
        end
      end
      ST_COPY: begin
        if (st.copy_done && (!pend_r || out_free)) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: cmd.load = in_valid;
      ST_COPY: begin
        cmd.emit_copy = pend_r && out_free;
        // one read in flight; the next goes out as the pending byte leaves
        cmd.issue     = !st.copy_done && (!pend_r || out_free);
      end
      ST_TAIL: cmd.emit_next = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.issue) begin
      pend_nxt = 1'b1;
    end else if (cmd.emit_copy) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
    if (cmd.emit_copy || cmd.emit_next) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- src/lz77_bitpacked_decoder_core.sv -----
// LZ77 decoder for a bit-packed token stream with a 4096-byte history.
// A result byte is registered at the output; a copy byte first passes the history read
// register. Input stalls while a token's copy and trailing bytes go out, plus out stalls.
// Throughput: one byte per cycle unless out stalls, set by the single history read port.
// Reset (rst_n low, synchronous): bit buffer, write pointer and output valid cleared;
// the history reads as zero until written, with no clearing pass.
`default_nettype none
module lz77_bitpacked_decoder_core
  import lzbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_stream_end,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_run_last
);

  lzbd_cmd_t    cmd;
  lzbd_status_t st;

  lzbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  lzbd_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_data_byte  (in_data_byte),
    .in_stream_end (in_stream_end),
    .cmd           (cmd),
    .st            (st),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last)
  );

endmodule
`default_nettype wire

// ----- src/lzbd_checker.sv -----
// Port-level checker for the LZ77 decoder core, bound to the top level.
`default_nettype none
module lzbd_checker
  import lzbd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [BYTE_W-1:0] in_data_byte,
  input wire logic              in_stream_end,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [BYTE_W-1:0] out_byte,
  input wire logic              out_run_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_run_last))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a result still waiting while input is open must close its item
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_stall |-> out_run_last)
    else $error("non-final result waiting while input open");

  // after a non-final transfer, the next byte of the same item follows at once
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_run_last |=> out_valid)
    else $error("result stream broke in the middle of an item");

endmodule

bind lz77_bitpacked_decoder_core lzbd_checker u_lzbd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_data_byte  (in_data_byte),
  .in_stream_end (in_stream_end),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .out_run_last  (out_run_last)
);
`default_nettype wire
